// ----- rtl/rpta_pkg.sv -----
// Shared types, constants and helpers for the RGB pixel tone adjust unit.
`timescale 1ns / 1ps
`default_nettype none

package rpta_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int LUMA_BITS    = 16;
  localparam int LUMA_R       = 19595;
  localparam int LUMA_G       = 38470;
  localparam int LUMA_B       = 7471;
  localparam int CONTRAST_MID = 128;
  localparam int TEN_SCALE    = 10 << FRAC_BITS;
  // floor(v / 10) as (v * 3277) >> 15, exact for v below 16384
  localparam int DIV10_MUL    = 3277;
  localparam int DIV10_SHIFT  = 15;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STAGE_EN  = 3'd0,
    CFG_EXP_GAIN  = 3'd1,
    CFG_CON_GAIN  = 3'd2,
    CFG_SAT_GAIN  = 3'd3,
    CFG_TEMP_AMT  = 3'd4
  } cfg_idx_e;

  // stage enable bits
  localparam int EN_EXPOSURE = 0;
  localparam int EN_CONTRAST = 1;
  localparam int EN_SATURATE = 2;
  localparam int EN_TEMP     = 3;

  typedef struct packed {
    logic [3:0]         stage_en;
    logic [15:0]        exp_gain;
    logic [15:0]        con_gain;
    logic [13:0]        sat_gain;
    logic signed [13:0] temp_amt;
  } cfg_t;

  // ch[0] red, ch[1] green, ch[2] blue
  typedef struct packed {
    logic [2:0][7:0] ch;
    logic            last;
  } pix_t;

  // clamp an already scaled value to 0..255
  function automatic logic [7:0] sat_u8(input logic signed [47:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 48'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rpta_cfg_regs.sv -----
// Configuration register file of the tone adjust unit.
`timescale 1ns / 1ps
`default_nettype none

module rpta_cfg_regs import rpta_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_STAGE_EN: cfg_d.stage_en = cfg_wdata_i[3:0];
        CFG_EXP_GAIN: cfg_d.exp_gain = cfg_wdata_i;
        CFG_CON_GAIN: cfg_d.con_gain = cfg_wdata_i;
        CFG_SAT_GAIN: cfg_d.sat_gain = cfg_wdata_i[13:0];
        CFG_TEMP_AMT: cfg_d.temp_amt = $signed(cfg_wdata_i[13:0]);
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stage_en <= '0;
      cfg_q.exp_gain <= 16'(1 << FRAC_BITS);
      cfg_q.con_gain <= 16'(1 << FRAC_BITS);
      cfg_q.sat_gain <= 14'(1 << FRAC_BITS);
      cfg_q.temp_amt <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/rpta_gain_stage.sv -----
// One registered gain stage: exposure (c*g) or contrast (128 + g*(c-128)).
`timescale 1ns / 1ps
`default_nettype none

module rpta_gain_stage import rpta_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        contrast_i,
  input  wire logic        enable_i,
  input  wire logic [15:0] gain_i,
  input  wire logic        valid_i,
  input  wire pix_t        pix_i,
  output logic             valid_o,
  output pix_t             pix_o
);

  localparam logic signed [26:0] MID_Q = 27'(CONTRAST_MID) <<< FRAC_BITS;

  logic valid_q;
  pix_t pix_q, pix_d;

  always_comb begin
    logic signed [8:0]  diff;
    logic signed [25:0] prod;
    logic signed [26:0] sum;
    logic signed [26:0] sh;
    pix_d = pix_i;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({1'b0, pix_i.ch[i]}) - (contrast_i ? 9'sd128 : 9'sd0);
      prod = diff * $signed({1'b0, gain_i});
      sum  = 27'(prod) + (contrast_i ? MID_Q : 27'sd0);
      sh   = sum >>> FRAC_BITS;
      if (enable_i) begin
        pix_d.ch[i] = sat_u8(48'(sh));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

// ----- rtl/rpta_sat_stage.sv -----
// Saturation: luma in the first register stage, blend toward luma in the second.
`timescale 1ns / 1ps
`default_nettype none

module rpta_sat_stage import rpta_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        enable_i,
  input  wire logic [13:0] gain_i,
  input  wire logic        valid_i,
  input  wire pix_t        pix_i,
  output logic             valid_o,
  output pix_t             pix_o
);

  logic        valid_a_q, valid_b_q;
  pix_t        pix_a_q, pix_b_q, pix_b_d;
  logic [23:0] luma_q, luma_d;

  assign luma_d = 24'(LUMA_R) * 24'(pix_i.ch[0])
                + 24'(LUMA_G) * 24'(pix_i.ch[1])
                + 24'(LUMA_B) * 24'(pix_i.ch[2]);

  always_comb begin
    logic signed [24:0] diff;
    logic signed [39:0] prod;
    logic signed [40:0] sum;
    logic signed [40:0] sh;
    pix_b_d = pix_a_q;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({1'b0, pix_a_q.ch[i], 16'b0}) - $signed({1'b0, luma_q});
      prod = diff * $signed({1'b0, gain_i});
      sum  = 41'(prod) + $signed(41'(luma_q) << FRAC_BITS);
      sh   = sum >>> (FRAC_BITS + LUMA_BITS);
      if (enable_i) begin
        pix_b_d.ch[i] = sat_u8(48'(sh));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_a_q <= pix_i;
    luma_q  <= luma_d;
    pix_b_q <= pix_b_d;
  end

  assign valid_o = valid_b_q;
  assign pix_o   = pix_b_q;

endmodule

`default_nettype wire

// ----- rtl/rpta_temp_stage.sv -----
// Temperature: products in the first register stage, scaling and clamp in the second.
`timescale 1ns / 1ps
`default_nettype none

module rpta_temp_stage import rpta_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               enable_i,
  input  wire logic signed [13:0] temp_i,
  input  wire logic               valid_i,
  input  wire pix_t               pix_i,
  output logic                    valid_o,
  output pix_t                    pix_o
);

  logic        warm;
  logic [13:0] tabs;
  logic [15:0] k_scale;
  logic [7:0]  push_c, scale_c;
  logic [22:0] push_num_d;
  logic [23:0] scale_num_d;

  logic        valid_a_q, valid_b_q;
  pix_t        pix_a_q, pix_b_q, pix_b_d;
  logic        warm_q;
  logic [22:0] push_num_q;
  logic [23:0] scale_num_q;

  // both branches scale the other channel by (10 - 3|t|) / 10 in Q12
  assign warm    = (temp_i > 14'sd0);
  assign tabs    = warm ? temp_i[13:0] : 14'(-15'(temp_i));
  assign k_scale = 16'(TEN_SCALE) - 16'(3 * 16'(tabs));
  assign push_c  = warm ? pix_i.ch[0] : pix_i.ch[2];
  assign scale_c = warm ? pix_i.ch[2] : pix_i.ch[0];

  assign push_num_d  = (23'(push_c) << (FRAC_BITS + 1))
                     + 23'(8'd255 - push_c) * 23'(tabs);
  assign scale_num_d = 24'(scale_c) * 24'(k_scale);

  always_comb begin
    logic [12:0] v;
    logic [24:0] qm;
    logic [7:0]  pushed, scaled;
    v       = 13'(scale_num_q >> FRAC_BITS);
    qm      = 25'(v) * 25'(DIV10_MUL);
    scaled  = sat_u8(48'(qm >> DIV10_SHIFT));
    pushed  = sat_u8(48'(push_num_q >> (FRAC_BITS + 1)));
    pix_b_d = pix_a_q;
    if (enable_i) begin
      pix_b_d.ch[0] = warm_q ? pushed : scaled;
      pix_b_d.ch[2] = warm_q ? scaled : pushed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_a_q     <= pix_i;
    warm_q      <= warm;
    push_num_q  <= push_num_d;
    scale_num_q <= scale_num_d;
    pix_b_q     <= pix_b_d;
  end

  assign valid_o = valid_b_q;
  assign pix_o   = pix_b_q;

endmodule

`default_nettype wire

// ----- rtl/rgb_pixel_tone_adjust_unit.sv -----
// Top level of the RGB pixel tone adjust unit: config registers and stage pipeline.
// A request passes the exposure, contrast, saturation and temperature stage registers.
// Throughput: one pixel per clock; each of the six stage registers holds one pixel.
// busy_o stays low: the pipeline never stalls and the receiver cannot stall it.
// Reset clears the valid bits and loads the register defaults (gains 1.0, all stages off).
`timescale 1ns / 1ps
`default_nettype none

module rgb_pixel_tone_adjust_unit import rpta_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [7:0]            red_in_i,
  input  wire logic [7:0]            green_in_i,
  input  wire logic [7:0]            blue_in_i,
  input  wire logic                  last_pixel_in_i,
  output logic                       result_valid_o,
  output logic [7:0]                 red_out_o,
  output logic [7:0]                 green_out_o,
  output logic [7:0]                 blue_out_o,
  output logic                       last_pixel_out_o
);

  cfg_t cfg;
  pix_t pix_in, pix_exp, pix_con, pix_sat, pix_out;
  logic accept, v_exp, v_con, v_sat, v_out;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign pix_in.ch[0] = red_in_i;
  assign pix_in.ch[1] = green_in_i;
  assign pix_in.ch[2] = blue_in_i;
  assign pix_in.last  = last_pixel_in_i;

  rpta_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rpta_gain_stage u_exposure (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .contrast_i (1'b0),
    .enable_i   (cfg.stage_en[EN_EXPOSURE]),
    .gain_i     (cfg.exp_gain),
    .valid_i    (accept),
    .pix_i      (pix_in),
    .valid_o    (v_exp),
    .pix_o      (pix_exp)
  );

  rpta_gain_stage u_contrast (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .contrast_i (1'b1),
    .enable_i   (cfg.stage_en[EN_CONTRAST]),
    .gain_i     (cfg.con_gain),
    .valid_i    (v_exp),
    .pix_i      (pix_exp),
    .valid_o    (v_con),
    .pix_o      (pix_con)
  );

  rpta_sat_stage u_saturate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (cfg.stage_en[EN_SATURATE]),
    .gain_i   (cfg.sat_gain),
    .valid_i  (v_con),
    .pix_i    (pix_con),
    .valid_o  (v_sat),
    .pix_o    (pix_sat)
  );

  rpta_temp_stage u_temp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (cfg.stage_en[EN_TEMP]),
    .temp_i   (cfg.temp_amt),
    .valid_i  (v_sat),
    .pix_i    (pix_sat),
    .valid_o  (v_out),
    .pix_o    (pix_out)
  );

  assign result_valid_o   = v_out;
  assign red_out_o        = pix_out.ch[0];
  assign green_out_o      = pix_out.ch[1];
  assign blue_out_o       = pix_out.ch[2];
  assign last_pixel_out_o = pix_out.last;

  // every accepted request produces a result strobe
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 result_valid_o)
    else $error("request did not produce a result after six cycles");

  // no result strobe without a matching request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##6 !result_valid_o)
    else $error("result strobe without a matching request");

  // the frame marker travels with its pixel
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 (last_pixel_out_o == $past(last_pixel_in_i, 6)))
    else $error("last pixel marker lost its pixel");

endmodule

`default_nettype wire
